// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the stencil RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define STEN_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Check that a condition never holds outside reset.
`define STEN_ASSERT_NEVER(label, clk, rstn, cond, msg) \
    `STEN_ASSERT(label, clk, rstn, !(cond), msg)

`endif

// ----- hdl/sten_pkg.sv -----
// Types, constants and register codes of the 13-point stencil mean core.
package sten_pkg;

    localparam int DEF_MAX_ROWS     = 256;
    localparam int DEF_MAX_COLS     = 256;
    localparam int DEF_VECTOR_LANES = 8;

    localparam int SAMPLE_W    = 32;
    localparam int DEPTH_W     = 12;
    localparam int DIM_W       = 9;
    localparam int STRIDE_W    = 7;
    localparam int PLEN_W      = 18;
    localparam int ROW_IDX_W   = 8;
    localparam int COL_IDX_W   = 8;
    localparam int SUM_W       = 36;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 12;
    localparam int QUEUE_DEPTH = 4;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_USED  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_USED   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_USED   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_STRIDE = 4'd3;

    // Register reset values
    localparam logic [DEPTH_W-1:0]  RST_DEPTH_USED  = 12'd128;
    localparam logic [DIM_W-1:0]    RST_ROWS_USED   = 9'd256;
    localparam logic [DIM_W-1:0]    RST_COLS_USED   = 9'd256;
    localparam logic [STRIDE_W-1:0] RST_STEP_STRIDE = 7'd1;

    // floor(u / 13) = (u * DIV13_RECIP) >> DIV13_SHIFT for u below 2**36
    localparam logic [36:0]      DIV13_RECIP = 37'd84577817522;
    localparam int               DIV13_SHIFT = 40;
    // Offset that makes any 13-sample sum non-negative: 13 * 2**31
    localparam logic [SUM_W-1:0] SUM_BIAS    = 36'd27917287424;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       volume_start;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mean_value;
        logic [DEPTH_W-1:0]         plane_index;
        logic [ROW_IDX_W-1:0]       row_index;
        logic [COL_IDX_W-1:0]       col_index;
    } out_item_t;

    // Effective geometry after clamping, plus delay lengths inputs
    typedef struct packed {
        logic [DEPTH_W-1:0]  depth;
        logic [DIM_W-1:0]    rows;
        logic [DIM_W-1:0]    cols;
        logic [STRIDE_W-1:0] stride;
        logic [DIM_W-1:0]    cols_c;
        logic [PLEN_W-1:0]   plane_len;
    } geom_t;

    typedef struct packed {
        logic [DEPTH_W-1:0]   k;
        logic [ROW_IDX_W-1:0] i;
        logic [COL_IDX_W-1:0] j;
    } coord_t;

    // Classified sample handed from the front to the back
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                sel;
        coord_t              pos;
    } q_item_t;

endpackage

// ----- hdl/sten_front.sv -----
// Front end: position counters and centre selection for each incoming sample.
`include "assert_macros.svh"

module sten_front #(
    parameter int VECTOR_LANES = sten_pkg::DEF_VECTOR_LANES
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  sten_pkg::in_item_t s_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  sten_pkg::geom_t    geom,
    input  logic               q_full,
    output logic               push,
    output sten_pkg::q_item_t  push_item
);
    import sten_pkg::*;

    localparam int LANE_W = $clog2(VECTOR_LANES + 1);

    logic [DEPTH_W-1:0]  plane_reg, plane_next;
    logic [DIM_W-1:0]    row_reg, row_next;
    logic [DIM_W-1:0]    col_reg, col_next;
    logic [STRIDE_W-1:0] kph_reg, kph_next;
    logic [STRIDE_W-1:0] iph_reg, iph_next;
    logic [STRIDE_W-1:0] blk_reg, blk_next;
    logic [LANE_W-1:0]   lane_reg, lane_next;

    logic [DEPTH_W-1:0]  ka;
    logic [DIM_W-1:0]    ia, jc, im1;
    logic [DEPTH_W:0]    k_inc;
    logic [DIM_W:0]      i_inc, j_inc;
    logic [STRIDE_W-1:0] kph_inc, iph_inc, blk_inc;
    logic [LANE_W-1:0]   lane_inc;
    logic                col_wrap, row_wrap, plane_wrap;
    logic                k_ok, i_ok, j_ok;

    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;

    // Locate the sample and step the counters
    always_comb begin
        ka = s_data.volume_start ? '0 : plane_reg;
        ia = s_data.volume_start ? '0 : row_reg;
        jc = s_data.volume_start ? '0 : col_reg;

        j_inc = {1'b0, jc} + 1'b1;
        i_inc = {1'b0, ia} + 1'b1;
        k_inc = {1'b0, ka} + 1'b1;

        col_wrap   = j_inc >= {1'b0, geom.cols};
        row_wrap   = col_wrap && (i_inc >= {1'b0, geom.rows});
        plane_wrap = row_wrap && (k_inc >= {1'b0, geom.depth});

        col_next   = col_wrap ? '0 : j_inc[DIM_W-1:0];
        row_next   = col_wrap ? (row_wrap ? '0 : i_inc[DIM_W-1:0]) : ia;
        plane_next = row_wrap ? (plane_wrap ? '0 : k_inc[DEPTH_W-1:0]) : ka;

        kph_inc  = kph_reg + 1'b1;
        iph_inc  = iph_reg + 1'b1;
        blk_inc  = blk_reg + 1'b1;
        lane_inc = lane_reg + 1'b1;

        // Plane phase starts at the first interior plane
        if (row_wrap && plane_next == DEPTH_W'(2)) begin
            kph_next = '0;
        end else if (row_wrap) begin
            kph_next = (kph_inc >= geom.stride) ? '0 : kph_inc;
        end else begin
            kph_next = kph_reg;
        end

        // Row phase starts at the first interior row
        if (col_wrap && row_next == DIM_W'(2)) begin
            iph_next = '0;
        end else if (col_wrap) begin
            iph_next = (iph_inc >= geom.stride) ? '0 : iph_inc;
        end else begin
            iph_next = iph_reg;
        end

        // Column lane and block phase start at column one
        if (col_next == DIM_W'(1)) begin
            lane_next = '0;
            blk_next  = '0;
        end else if (32'(lane_inc) >= VECTOR_LANES) begin
            lane_next = '0;
            blk_next  = (blk_inc >= geom.stride) ? '0 : blk_inc;
        end else begin
            lane_next = lane_inc;
            blk_next  = blk_reg;
        end

        // Centre lies one plane and one row behind the sample
        k_ok = (ka >= DEPTH_W'(2)) && (k_inc <= {1'b0, geom.depth}) && (kph_reg == '0);
        i_ok = (ia >= DIM_W'(2)) && (i_inc <= {1'b0, geom.rows}) && (iph_reg == '0);
        j_ok = (jc != '0) && (({1'b0, jc} + 2'd2) <= {1'b0, geom.cols}) && (blk_reg == '0);

        im1 = ia - 1'b1;
        push_item.sample = s_data.sample;
        push_item.sel    = k_ok && i_ok && j_ok;
        push_item.pos.k  = ka - 1'b1;
        push_item.pos.i  = im1[ROW_IDX_W-1:0];
        push_item.pos.j  = jc[COL_IDX_W-1:0];
    end

    // Advance the position on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_reg <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            kph_reg   <= '0;
            iph_reg   <= '0;
            blk_reg   <= '0;
            lane_reg  <= '0;
        end else if (push) begin
            plane_reg <= plane_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            kph_reg   <= kph_next;
            iph_reg   <= iph_next;
            blk_reg   <= blk_next;
            lane_reg  <= lane_next;
        end
    end

    `STEN_ASSERT(a_sel_interior_plane, aclk, aresetn, (push && push_item.sel) |-> (push_item.pos.k != '0), "selected centre on plane zero")

endmodule

// ----- hdl/sten_queue.sv -----
// Short queue between the classifying front and the arithmetic back.
`include "assert_macros.svh"

module sten_queue #(
    parameter int DEPTH = sten_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  sten_pkg::q_item_t push_item,
    output logic              full,
    input  logic              pop,
    output logic              pop_valid,
    output sten_pkg::q_item_t pop_item
);
    import sten_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_item_t            slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_reg, rd_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_pop;

    assign full      = (32'(count_reg) == DEPTH);
    assign pop_valid = (count_reg != '0);
    assign pop_item  = slot_reg[rd_reg];
    assign do_pop    = pop && pop_valid;

    // Store pushed items
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_reg] <= push_item;
        end
    end

    // Move pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (32'(wr_reg) == DEPTH - 1) ? '0 : wr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_reg <= (32'(rd_reg) == DEPTH - 1) ? '0 : rd_reg + 1'b1;
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `STEN_ASSERT_NEVER(a_no_push_when_full, aclk, aresetn, push && full, "push into full queue")

endmodule

// ----- hdl/sten_delay.sv -----
// Variable-length sample delay built on a circular memory with registered read.
module sten_delay #(
    parameter int DEPTH = sten_pkg::DEF_MAX_COLS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          shift,
    input  logic [$clog2(DEPTH+1)-1:0]    len,
    input  logic [sten_pkg::SAMPLE_W-1:0] din,
    output logic [sten_pkg::SAMPLE_W-1:0] dout
);
    import sten_pkg::*;

    localparam int LEN_W = $clog2(DEPTH + 1);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rd_reg;
    logic [PTR_W-1:0]    ptr_reg;
    logic [LEN_W:0]      ptr_inc;

    assign ptr_inc = (LEN_W + 1)'(ptr_reg) + 1'b1;
    assign dout    = rd_reg;

    // Read the oldest entry and overwrite it with the new sample
    always_ff @(posedge aclk) begin
        if (shift) begin
            rd_reg       <= mem[ptr_reg];
            mem[ptr_reg] <= din;
        end
    end

    // Wrap the pointer at the programmed length
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
        end else if (shift) begin
            ptr_reg <= (ptr_inc >= {1'b0, len}) ? '0 : ptr_inc[PTR_W-1:0];
        end
    end

endmodule

// ----- hdl/sten_back.sv -----
// Back end: neighborhood delay chain, 13-input adder tree and divide by 13.
`include "assert_macros.svh"

module sten_back #(
    parameter int MAX_ROWS = sten_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = sten_pkg::DEF_MAX_COLS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  sten_pkg::geom_t     geom,
    input  logic                pop_valid,
    input  sten_pkg::q_item_t   pop_item,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output sten_pkg::out_item_t m_data
);
    import sten_pkg::*;

    localparam int COL_LW   = $clog2(MAX_COLS + 1);
    localparam int PLANE_D  = MAX_ROWS * MAX_COLS;
    localparam int PLANE_LW = $clog2(PLANE_D + 1);
    localparam int NSTAGE   = 7;
    localparam int OUT_ST   = NSTAGE - 1;
    localparam logic [18:0] RECIP_HI = DIV13_RECIP[36:18];
    localparam logic [17:0] RECIP_LO = DIV13_RECIP[17:0];

    logic                en;
    logic [COL_LW-1:0]   len_c2, len_c1;
    logic [PLANE_LW-1:0] len_pl;

    logic [SAMPLE_W-1:0] t0_reg, tc_reg, tpc_reg, tpc1_reg, t2pc1_reg;
    logic [SAMPLE_W-1:0] d1, d2, d3, d4, d5, d6, d7, d8;
    logic [SAMPLE_W-1:0] tap [13];

    logic                valid_reg [NSTAGE];
    coord_t              pos_reg   [NSTAGE];

    logic signed [SUM_W-1:0] s1_reg [7];
    logic signed [SUM_W-1:0] s2_reg [4];
    logic signed [SUM_W-1:0] s3_reg [2];
    logic [SUM_W-1:0]        u_reg;
    logic [36:0]             pp_hh_reg, pp_lh_reg;
    logic [35:0]             pp_hl_reg, pp_ll_reg;
    logic [72:0]             prod;
    logic [SAMPLE_W-1:0]     mean_reg;

    // Whole pipeline moves unless the result register is held
    assign en      = !valid_reg[OUT_ST] || m_ready;
    assign pop     = en && pop_valid;
    assign m_valid = valid_reg[OUT_ST];

    assign len_c2 = COL_LW'(geom.cols_c - DIM_W'(2));
    assign len_c1 = COL_LW'(geom.cols_c - DIM_W'(1));
    assign len_pl = PLANE_LW'(geom.plane_len);

    // Delay chain: each memory adds its length plus one sample
    sten_delay #(.DEPTH(MAX_COLS)) u_d1 (
        .aclk(aclk), .aresetn(aresetn), .shift(pop), .len(len_c2), .din(t0_reg), .dout(d1));
    sten_delay #(.DEPTH(MAX_COLS)) u_d2 (
        .aclk(aclk), .aresetn(aresetn), .shift(pop), .len(len_c1), .din(tc_reg), .dout(d2));
    sten_delay #(.DEPTH(PLANE_D)) u_d3 (
        .aclk(aclk), .aresetn(aresetn), .shift(pop), .len(len_pl), .din(d2), .dout(d3));
    sten_delay #(.DEPTH(MAX_COLS)) u_d4 (
        .aclk(aclk), .aresetn(aresetn), .shift(pop), .len(len_c2), .din(d3), .dout(d4));
    sten_delay #(.DEPTH(MAX_COLS)) u_d5 (
        .aclk(aclk), .aresetn(aresetn), .shift(pop), .len(len_c2), .din(tpc1_reg), .dout(d5));
    sten_delay #(.DEPTH(PLANE_D)) u_d6 (
        .aclk(aclk), .aresetn(aresetn), .shift(pop), .len(len_pl), .din(d5), .dout(d6));
    sten_delay #(.DEPTH(MAX_COLS)) u_d7 (
        .aclk(aclk), .aresetn(aresetn), .shift(pop), .len(len_c1), .din(d6), .dout(d7));
    sten_delay #(.DEPTH(MAX_COLS)) u_d8 (
        .aclk(aclk), .aresetn(aresetn), .shift(pop), .len(len_c2), .din(t2pc1_reg), .dout(d8));

    // Single-sample links of the chain
    always_ff @(posedge aclk) begin
        if (pop) begin
            t0_reg    <= pop_item.sample;
            tc_reg    <= d1;
            tpc_reg   <= d4;
            tpc1_reg  <= tpc_reg;
            t2pc1_reg <= d7;
        end
    end

    // Gather the 13 neighborhood taps
    always_comb begin
        tap[0]  = t0_reg;
        tap[1]  = d1;
        tap[2]  = tc_reg;
        tap[3]  = d2;
        tap[4]  = d3;
        tap[5]  = d4;
        tap[6]  = tpc_reg;
        tap[7]  = tpc1_reg;
        tap[8]  = d5;
        tap[9]  = d6;
        tap[10] = d7;
        tap[11] = t2pc1_reg;
        tap[12] = d8;
    end

    // Track valid and coordinates down the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < NSTAGE; s++) begin
                valid_reg[s] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= pop_valid && pop_item.sel;
            for (int s = 1; s < NSTAGE; s++) begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pos_reg[0] <= pop_item.pos;
            for (int s = 1; s < NSTAGE; s++) begin
                pos_reg[s] <= pos_reg[s-1];
            end
        end
    end

    // Adder tree, bias, partial products and final scaling
    always_comb begin
        prod = (73'(pp_hh_reg) << 36) + ((73'(pp_hl_reg) + 73'(pp_lh_reg)) << 18)
             + 73'(pp_ll_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int n = 0; n < 6; n++) begin
                s1_reg[n] <= SUM_W'(signed'(tap[2*n])) + SUM_W'(signed'(tap[2*n+1]));
            end
            s1_reg[6] <= SUM_W'(signed'(tap[12]));

            s2_reg[0] <= s1_reg[0] + s1_reg[1];
            s2_reg[1] <= s1_reg[2] + s1_reg[3];
            s2_reg[2] <= s1_reg[4] + s1_reg[5];
            s2_reg[3] <= s1_reg[6];

            s3_reg[0] <= s2_reg[0] + s2_reg[1];
            s3_reg[1] <= s2_reg[2] + s2_reg[3];

            u_reg <= SUM_W'(s3_reg[0] + s3_reg[1]) + SUM_BIAS;

            pp_hh_reg <= 37'(u_reg[35:18]) * 37'(RECIP_HI);
            pp_hl_reg <= 36'(u_reg[35:18]) * 36'(RECIP_LO);
            pp_lh_reg <= 37'(u_reg[17:0]) * 37'(RECIP_HI);
            pp_ll_reg <= 36'(u_reg[17:0]) * 36'(RECIP_LO);

            // Remove the bias by flipping the sign bit of the quotient
            mean_reg <= prod[DIV13_SHIFT+SAMPLE_W-1:DIV13_SHIFT] ^ {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
    end

    assign m_data.mean_value  = signed'(mean_reg);
    assign m_data.plane_index = pos_reg[OUT_ST].k;
    assign m_data.row_index   = pos_reg[OUT_ST].i;
    assign m_data.col_index   = pos_reg[OUT_ST].j;

    `STEN_ASSERT(a_no_pop_when_stalled, aclk, aresetn, (m_valid && !m_ready) |-> !pop, "queue popped while result held")
    `STEN_ASSERT(a_held_result_stays, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(mean_reg)), "held result changed")

endmodule

// ----- hdl/stencil_3d_13point_average_core.sv -----
// Top level of the 13-point 3D stencil mean core.
//
// Usage: samples of a volume enter on the s_ channel in raster order (plane,
// row, column), one per transaction; volume_start marks the first sample of
// a volume. For each selected interior centre (k, i, j) one result leaves on
// the m_ channel once the sample at (k+1, i+1, j) has been taken: the floored
// mean of the 13 neighborhood samples together with the centre coordinates.
// Non-selected points give no transaction.
// Throughput: one sample per cycle when not stalled, set by the single write
// and read port of each delay memory and the fully pipelined adder tree and
// divide by 13. Registers from acceptance to m_valid, in order: queue, tap
// registers, three adder stages, bias, partial products, output.
// When the receiver stalls, the result register holds and the pipeline
// freezes; s_ready stays high until the 4-entry queue fills.
// Configuration: cfg_ready is always high; write only while the core is
// empty. Reset restores the register defaults and position counters; delay
// memory contents are not cleared.
module stencil_3d_13point_average_core #(
    parameter int MAX_ROWS     = sten_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS     = sten_pkg::DEF_MAX_COLS,
    parameter int VECTOR_LANES = sten_pkg::DEF_VECTOR_LANES
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  sten_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output sten_pkg::out_item_t             m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sten_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sten_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sten_pkg::*;

    logic [DEPTH_W-1:0]  depth_reg;
    logic [DIM_W-1:0]    rows_reg, cols_reg, rows_eff, cols_eff, rows_c, cols_c;
    logic [STRIDE_W-1:0] stride_reg;
    geom_t               geom;

    logic                push, q_full, pop, pop_valid;
    q_item_t             push_item, pop_item;

    assign cfg_ready = 1'b1;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg  <= RST_DEPTH_USED;
            rows_reg   <= RST_ROWS_USED;
            cols_reg   <= RST_COLS_USED;
            stride_reg <= RST_STEP_STRIDE;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_DEPTH_USED:  depth_reg  <= cfg_data[DEPTH_W-1:0];
                REG_ROWS_USED:   rows_reg   <= cfg_data[DIM_W-1:0];
                REG_COLS_USED:   cols_reg   <= cfg_data[DIM_W-1:0];
                REG_STEP_STRIDE: stride_reg <= cfg_data[STRIDE_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp geometry and derive delay lengths
    always_comb begin
        rows_eff = (rows_reg == '0) ? DIM_W'(1)
                 : ((32'(rows_reg) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : rows_reg);
        cols_eff = (cols_reg == '0) ? DIM_W'(1)
                 : ((32'(cols_reg) > MAX_COLS) ? DIM_W'(MAX_COLS) : cols_reg);
        rows_c   = (rows_eff < DIM_W'(3)) ? DIM_W'(3) : rows_eff;
        cols_c   = (cols_eff < DIM_W'(3)) ? DIM_W'(3) : cols_eff;

        geom.depth     = (depth_reg == '0) ? DEPTH_W'(1) : depth_reg;
        geom.rows      = rows_eff;
        geom.cols      = cols_eff;
        geom.stride    = (stride_reg == '0) ? STRIDE_W'(1) : stride_reg;
        geom.cols_c    = cols_c;
        geom.plane_len = PLEN_W'(cols_c) * PLEN_W'(rows_c - DIM_W'(2)) - 1'b1;
    end

    sten_front #(.VECTOR_LANES(VECTOR_LANES)) u_front (
        .aclk(aclk), .aresetn(aresetn), .s_data(s_data), .s_valid(s_valid),
        .s_ready(s_ready), .geom(geom), .q_full(q_full), .push(push),
        .push_item(push_item));

    sten_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(push), .push_item(push_item),
        .full(q_full), .pop(pop), .pop_valid(pop_valid), .pop_item(pop_item));

    sten_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .geom(geom), .pop_valid(pop_valid),
        .pop_item(pop_item), .pop(pop), .m_valid(m_valid), .m_ready(m_ready),
        .m_data(m_data));

endmodule
